FILE: rtl/ppf_pkg.sv
package ppf_pkg;

  // Fixed limits of the timer
  localparam int unsigned PERIOD_LIMIT   = 65536;
  localparam int unsigned PRESCALE_LIMIT = 31;
  localparam int unsigned PERIOD_SHIFT   = $clog2(PERIOD_LIMIT);
  localparam int unsigned TICKS_MAX      = (PRESCALE_LIMIT + 1) * PERIOD_LIMIT;

  // Field widths
  localparam int unsigned HZ_W    = 32;
  localparam int unsigned DUTY_W  = 17;
  localparam int unsigned PRE_W   = 5;
  localparam int unsigned PER_W   = 17;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PROD_W  = PER_W + DUTY_W;

  // Stream and configuration widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = 2 + PRE_W + 2 * PER_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_HZ    = 8'd0,
    REG_FREQUENCY_HZ = 8'd1,
    REG_DUTY         = 8'd2,
    REG_RUN_ENABLE   = 8'd3
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic step;       // advance counters and load the result
    logic check;      // clear counters, check the frequency range
    logic div_start;  // launch the divider
    logic div_sel;    // 0: source/frequency, 1: ticks/(prescaler+1)
    logic ld_ticks;   // capture the first quotient
    logic pre_err;    // flag the prescaler overflow
    logic ld_per;     // capture the period quotient
    logic mul;        // form period times duty
    logic commit;     // write the new settings
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_en;
    logic settings_ready;
    logic freq_bad;
    logic ticks_big;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/ppf_div.sv
module ppf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppf_pkg::HZ_W-1:0]   dividend_i,
  input  logic [ppf_pkg::HZ_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic [ppf_pkg::HZ_W-1:0]   quotient_o
);

  localparam int unsigned W     = ppf_pkg::HZ_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_o  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

FILE: rtl/ppf_dp.sv
module ppf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_write_i,
  input  logic [ppf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ppf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              tick_i,
  input  ppf_pkg::cmd_t                     cmd_i,
  output ppf_pkg::sts_t                     sts_o,
  output logic                              pin_o,
  output logic                              err_o,
  output logic [ppf_pkg::PRE_W-1:0]         pre_o,
  output logic [ppf_pkg::PER_W-1:0]         per_o,
  output logic [ppf_pkg::PER_W-1:0]         high_o
);

  localparam int unsigned HZ_W   = ppf_pkg::HZ_W;
  localparam int unsigned DUTY_W = ppf_pkg::DUTY_W;
  localparam int unsigned PRE_W  = ppf_pkg::PRE_W;
  localparam int unsigned PER_W  = ppf_pkg::PER_W;
  localparam int unsigned CNT_W  = ppf_pkg::CNT_W;
  localparam int unsigned PROD_W = ppf_pkg::PROD_W;
  localparam int unsigned HI_W   = PROD_W - ppf_pkg::PERIOD_SHIFT;

  // Configuration registers
  logic [HZ_W-1:0]   src_q, freq_q;
  logic [DUTY_W-1:0] duty_q;
  logic              run_q;
  logic              ready_q;

  // Settings and working registers
  logic              err_q;
  logic [PRE_W-1:0]  pre_q, pre_new_q;
  logic [PER_W-1:0]  per_q, per_new_q;
  logic [PER_W-1:0]  high_q;
  logic [PRE_W-1:0]  psc_q;
  logic [CNT_W-1:0]  pc_q;
  logic [HZ_W-1:0]   ticks_q;
  logic [PROD_W-1:0] prod_q;
  logic              tick_q;

  // Result register
  logic              pin_out_q, err_out_q;
  logic [PRE_W-1:0]  pre_out_q;
  logic [PER_W-1:0]  per_out_q, high_out_q;

  logic [HZ_W-1:0]   div_a, div_b, quo;
  logic              div_done;
  logic [HZ_W:0]     ceil_w;
  logic [PRE_W-1:0]  pre_calc;
  logic [HI_W-1:0]   hi_raw;
  logic [PER_W-1:0]  hi_calc;
  logic              tick_sel;
  logic [PRE_W-1:0]  psc_nx;
  logic [CNT_W-1:0]  pc_nx;
  logic [PER_W-1:0]  pc_inc;

  // Divider operand selection
  assign ceil_w   = ({1'b0, ticks_q} + (HZ_W + 1)'(ppf_pkg::PERIOD_LIMIT - 1))
                    >> ppf_pkg::PERIOD_SHIFT;
  assign pre_calc = PRE_W'(ceil_w - (HZ_W + 1)'(1));
  assign div_a    = cmd_i.div_sel ? ticks_q : src_q;
  assign div_b    = cmd_i.div_sel ? (HZ_W'(pre_calc) + HZ_W'(1)) : freq_q;

  ppf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // High count from the registered product, clamped to the period
  assign hi_raw  = prod_q[PROD_W-1:ppf_pkg::PERIOD_SHIFT];
  assign hi_calc = (hi_raw > HI_W'(per_new_q)) ? per_new_q : PER_W'(hi_raw);

  // Counter advance for one step
  assign tick_sel = cmd_i.take ? tick_i : tick_q;
  assign pc_inc   = PER_W'(pc_q) + PER_W'(1);
  always_comb begin
    psc_nx = psc_q;
    pc_nx  = pc_q;
    if (!run_q) begin
      psc_nx = '0;
      pc_nx  = '0;
    end else if (!err_q && tick_sel) begin
      if (psc_q >= pre_q) begin
        psc_nx = '0;
        pc_nx  = (pc_inc >= per_q) ? '0 : CNT_W'(pc_inc);
      end else begin
        psc_nx = psc_q + PRE_W'(1);
      end
    end
  end

  // Configuration writes and settings state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= '0;
      freq_q  <= '0;
      duty_q  <= '0;
      run_q   <= 1'b0;
      ready_q <= 1'b0;
      err_q   <= 1'b0;
      pre_q   <= '0;
      per_q   <= PER_W'(1);
      high_q  <= '0;
      psc_q   <= '0;
      pc_q    <= '0;
    end else begin
      if (cfg_write_i) begin
        unique case (cfg_index_i)
          ppf_pkg::REG_SOURCE_HZ:    src_q  <= cfg_data_i[HZ_W-1:0];
          ppf_pkg::REG_FREQUENCY_HZ: freq_q <= cfg_data_i[HZ_W-1:0];
          ppf_pkg::REG_DUTY:         duty_q <= cfg_data_i[DUTY_W-1:0];
          ppf_pkg::REG_RUN_ENABLE: begin
            run_q   <= cfg_data_i[0];
            ready_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.check) begin
        ready_q <= 1'b1;
        psc_q   <= '0;
        pc_q    <= '0;
        if (sts_o.freq_bad) begin
          err_q <= 1'b1;
        end
      end
      if (cmd_i.pre_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        err_q  <= 1'b0;
        pre_q  <= pre_new_q;
        per_q  <= per_new_q;
        high_q <= hi_calc;
      end
      if (cmd_i.step) begin
        psc_q <= psc_nx;
        pc_q  <= pc_nx;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      tick_q <= tick_i;
    end
    if (cmd_i.ld_ticks) begin
      ticks_q <= quo;
    end
    if (cmd_i.div_start && cmd_i.div_sel) begin
      pre_new_q <= pre_calc;
    end
    if (cmd_i.ld_per) begin
      per_new_q <= (quo == '0) ? PER_W'(1) : quo[PER_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(per_new_q) * PROD_W'(duty_q);
    end
    if (cmd_i.step) begin
      pin_out_q  <= run_q && !err_q && ((PER_W'(pc_nx)) < high_q);
      err_out_q  <= err_q;
      pre_out_q  <= pre_q;
      per_out_q  <= per_q;
      high_out_q <= high_q;
    end
  end

  assign sts_o.run_en         = run_q;
  assign sts_o.settings_ready = ready_q;
  assign sts_o.freq_bad       = (freq_q == '0) || (freq_q > (src_q >> 1));
  assign sts_o.ticks_big      = ticks_q > HZ_W'(ppf_pkg::TICKS_MAX);
  assign sts_o.div_done       = div_done;

  assign pin_o  = pin_out_q;
  assign err_o  = err_out_q;
  assign pre_o  = pre_out_q;
  assign per_o  = per_out_q;
  assign high_o = high_out_q;

endmodule

FILE: rtl/ppf_ctrl.sv
module ppf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ppf_pkg::sts_t sts_i,
  output ppf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_PRE   = 3'd3;
  localparam logic [2:0] ST_DIV2  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_HIGH  = 3'd6;
  localparam logic [2:0] ST_STEP  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       take;

  // Accept a new item in idle once the result slot is free or draining
  assign in_ready_o = (state_q == ST_IDLE) && (!oval_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_o.take = 1'b1;
          if (sts_i.run_en && !sts_i.settings_ready) begin
            state_d = ST_CHECK;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.freq_bad) begin
          state_d = ST_STEP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.ld_ticks = 1'b1;
          state_d        = ST_PRE;
        end
      end
      ST_PRE: begin
        if (sts_i.ticks_big) begin
          cmd_o.pre_err = 1'b1;
          state_d       = ST_STEP;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.ld_per = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_HIGH;
      end
      ST_HIGH: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    oval_d = oval_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (cmd_o.step) begin
      oval_d = 1'b1;
    end
  end

  assign out_valid_o = oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

endmodule

FILE: rtl/prescaled_pwm_from_frequency_top.sv
// Channel   Direction  Signals                          Content
// s_axis    in         tvalid/tready/tdata[7:0]          source_tick
// m_axis    out        tvalid/tready/tdata[47:0]         pin, error, prescaler, period, high
// cfg       in         cfg_valid_i/cfg_ready_o/index/data register write
//
// An item is stepped in the cycle it is taken when the settings are current or run is off.
// The first item after run_enable is written, with run enabled, runs the settings
// computation: a range check, two passes of the shared bit-serial divider, the
// prescaler, the product and the commit; a range error skips to the final step.
// Reset clears the configuration and the counters; the settings go to zero, period one.
// A stalled result holds in the output register; the next item waits for it.
module prescaled_pwm_from_frequency_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ppf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] source_tick
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] pin_level, [1] range_error, [6:2] prescaler_value,
  // [23:7] period_ticks, [40:24] high_ticks, rest zero
  output logic [ppf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ppf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ppf_pkg::cmd_t                  cmd;
  ppf_pkg::sts_t                  sts;
  logic                           pin, err;
  logic [ppf_pkg::PRE_W-1:0]      pre;
  logic [ppf_pkg::PER_W-1:0]      per, high;

  assign cfg_ready_o = 1'b1;

  ppf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pin_o       (pin),
    .err_o       (err),
    .pre_o       (pre),
    .per_o       (per),
    .high_o      (high)
  );

  assign m_axis_tdata = ppf_pkg::OUT_TDATA_W'({high, per, pre, err, pin});

endmodule

FILE: rtl/ppf_chk.sv
module ppf_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ppf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic                      pin, err;
  logic [ppf_pkg::PER_W-1:0] per, high;

  assign pin  = m_axis_tdata[0];
  assign err  = m_axis_tdata[1];
  assign per  = m_axis_tdata[ppf_pkg::PRE_W + 2 + ppf_pkg::PER_W - 1:ppf_pkg::PRE_W + 2];
  assign high = m_axis_tdata[ppf_pkg::PRE_W + 2 + 2 * ppf_pkg::PER_W - 1:
                             ppf_pkg::PRE_W + 2 + ppf_pkg::PER_W];

  // An error result never drives the pin high
  a_err_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(pin && err))
    else $error("pin high with range error");

  // High count never exceeds the period, period never zero
  a_high_le_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (high <= per) && (per != '0))
    else $error("high count above period");

  // A high pin needs a nonzero high count
  a_pin_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && pin) |-> (high != '0))
    else $error("pin high with zero high count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Hold off new input while a result waits
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while a result waits");

endmodule

bind prescaled_pwm_from_frequency_top ppf_chk u_ppf_chk (.*);
